>>> rtl/core/njm_pkg.sv
`timescale 1ns / 1ps

package njm_pkg;

    // Table capacity and the widths that follow from it.
    localparam int MAX_JETS = 64;
    localparam int IDX_W    = (MAX_JETS > 1) ? $clog2(MAX_JETS) : 1;
    localparam int CNT_W    = $clog2(MAX_JETS + 1);

    // Fixed field widths.
    localparam int ETA_W    = 18;
    localparam int PHI_W    = 16;
    localparam int PID_W    = 24;
    localparam int DR_W     = 37;
    localparam int JI_W     = 6;
    localparam int CFG_IDX_W = 2;
    localparam int DETA_W   = ETA_W + 1;
    localparam int ESQ_W    = 2 * ETA_W;
    localparam int PSQ_W    = 2 * PHI_W - 1;
    localparam int JET_W    = ETA_W + PHI_W;

    localparam logic [DR_W-1:0] MAX_DR_RESET = 37'd27196225;

    // Lepton particle id codes (electron, muon, tau).
    localparam logic signed [PID_W-1:0] PID_ELE = 24'sd11;
    localparam logic signed [PID_W-1:0] PID_MU  = 24'sd13;
    localparam logic signed [PID_W-1:0] PID_TAU = 24'sd15;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_CONST = 2'd2,
        ACT_MATCH = 2'd3
    } njm_action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DR  = 2'd0,
        CFG_EXCLUDE = 2'd1
    } njm_cfg_idx_t;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // input item taken this cycle
        logic issue;    // read the table entry at the walk address
        logic push;     // move the match result into the output register
    } njm_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic count_zero;
        logic last_addr;
        logic pipe_busy;
        logic out_free;
    } njm_status_t;

endpackage

>>> rtl/core/njm_ram.sv
`timescale 1ns / 1ps

module njm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/njm_ctrl.sv
`timescale 1ns / 1ps

module njm_ctrl
    import njm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  njm_status_t status,
    output njm_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_PUSH  = 4'b1000
    } njm_state_t;

    njm_state_t state_reg;
    njm_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid && (njm_action_t'(action) == ACT_MATCH))
                begin
                    state_next = status.count_zero ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.issue = 1'b1;
                if (status.last_addr)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/njm_dp.sv
`timescale 1ns / 1ps

module njm_dp
    import njm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  njm_cmd_t                cmd,
    output njm_status_t             status,
    input  logic [1:0]              action,
    input  logic signed [ETA_W-1:0] eta,
    input  logic signed [PHI_W-1:0] phi,
    input  logic signed [PID_W-1:0] particle_id,
    input  logic                    cfg_valid,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DR_W-1:0]         cfg_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    matched,
    output logic [JI_W-1:0]         jet_index,
    output logic [DR_W-1:0]         distance_squared,
    output logic                    overflow
);

    // Configuration.
    logic [DR_W-1:0] max_dr_reg;
    logic [DR_W-1:0] max_dr_next;
    logic            excl_reg;
    logic            excl_next;

    // Table bookkeeping.
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic [CNT_W-1:0] count_m1;

    // Walk.
    logic [IDX_W-1:0]        addr_reg;
    logic [IDX_W-1:0]        addr_next;
    logic signed [ETA_W-1:0] tau_eta_reg;
    logic signed [PHI_W-1:0] tau_phi_reg;

    // Table write side.
    logic             jet_we;
    logic             mark_we;
    logic [IDX_W-1:0] mark_waddr;
    logic             mark_wdata;
    logic [JET_W-1:0] jet_rdata;
    logic             mark_rdata;

    // Distance pipeline.
    logic                    rd_valid_reg;
    logic [IDX_W-1:0]        rd_idx_reg;
    logic                    sq_valid_reg;
    logic [IDX_W-1:0]        sq_idx_reg;
    logic [ESQ_W-1:0]        eta_sq_reg;
    logic [PSQ_W-1:0]        phi_sq_reg;
    logic                    sum_valid_reg;
    logic [IDX_W-1:0]        sum_idx_reg;
    logic [DR_W-1:0]         sum_reg;
    logic signed [DETA_W-1:0] deta;
    logic signed [PHI_W-1:0]  dphi;
    logic signed [2*DETA_W-1:0] deta_sq;
    logic signed [2*PHI_W-1:0]  dphi_sq;
    logic                    take;

    // Running best.
    logic             found_reg;
    logic             found_next;
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] best_idx_next;
    logic [DR_W-1:0]  best_d_reg;
    logic [DR_W-1:0]  best_d_next;

    // Output register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic [JI_W-1:0]  jet_index_reg;
    logic [DR_W-1:0]  dist_reg;
    logic             overflow_reg;
    logic [JI_W+IDX_W-1:0] idx_ext;

    logic is_lepton;

    assign count_m1  = count_reg - CNT_W'(1);
    assign is_lepton = (particle_id == PID_ELE) || (particle_id == -PID_ELE) ||
                       (particle_id == PID_MU)  || (particle_id == -PID_MU)  ||
                       (particle_id == PID_TAU) || (particle_id == -PID_TAU);

    always_comb
    begin
        max_dr_next = max_dr_reg;
        excl_next   = excl_reg;
        if (cfg_valid)
        begin
            unique case (njm_cfg_idx_t'(cfg_index))
                CFG_MAX_DR:  max_dr_next = cfg_data;
                CFG_EXCLUDE: excl_next   = cfg_data[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        jet_we     = 1'b0;
        mark_we    = 1'b0;
        mark_waddr = count_reg[IDX_W-1:0];
        mark_wdata = 1'b0;
        if (cmd.accept)
        begin
            unique case (njm_action_t'(action))
                ACT_CLEAR:
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                ACT_LOAD:
                begin
                    if (count_reg < CNT_W'(MAX_JETS))
                    begin
                        jet_we     = 1'b1;
                        mark_we    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                ACT_CONST:
                begin
                    // A lepton constituent marks the latest stored jet; after a dropped
                    // load it belongs to no stored jet and is ignored.
                    if ((count_reg != '0) && !ovf_reg && is_lepton)
                    begin
                        mark_we    = 1'b1;
                        mark_waddr = count_m1[IDX_W-1:0];
                        mark_wdata = 1'b1;
                    end
                end
                ACT_MATCH: ;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        addr_next = addr_reg;
        if (cmd.accept)
        begin
            addr_next = '0;
        end
        else if (cmd.issue)
        begin
            addr_next = IDX_W'(addr_reg + IDX_W'(1));
        end
    end

    njm_ram #(
        .WIDTH (JET_W),
        .DEPTH (MAX_JETS)
    ) u_jet_ram (
        .clk   (clk),
        .we    (jet_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({eta, phi}),
        .re    (cmd.issue),
        .raddr (addr_reg),
        .rdata (jet_rdata)
    );

    njm_ram #(
        .WIDTH (1),
        .DEPTH (MAX_JETS)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (cmd.issue),
        .raddr (addr_reg),
        .rdata (mark_rdata)
    );

    // Differences; the phi difference wraps in its own width.
    assign deta    = DETA_W'(tau_eta_reg) - DETA_W'($signed(jet_rdata[JET_W-1:PHI_W]));
    assign dphi    = tau_phi_reg - $signed(jet_rdata[PHI_W-1:0]);
    assign deta_sq = deta * deta;
    assign dphi_sq = dphi * dphi;

    assign take = sum_valid_reg && (sum_reg < max_dr_reg) &&
                  (!found_reg || (sum_reg < best_d_reg));

    always_comb
    begin
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_d_next   = best_d_reg;
        if (cmd.accept)
        begin
            found_next    = 1'b0;
            best_idx_next = '0;
            best_d_next   = '0;
        end
        else if (take)
        begin
            found_next    = 1'b1;
            best_idx_next = sum_idx_reg;
            best_d_next   = sum_reg;
        end
    end

    assign idx_ext = {{JI_W{1'b0}}, best_idx_reg};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dr_reg    <= MAX_DR_RESET;
            excl_reg      <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            max_dr_reg    <= max_dr_next;
            excl_reg      <= excl_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            addr_reg      <= addr_next;
            rd_valid_reg  <= cmd.issue;
            sq_valid_reg  <= rd_valid_reg && !(excl_reg && mark_rdata);
            sum_valid_reg <= sq_valid_reg;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            tau_eta_reg <= eta;
            tau_phi_reg <= phi;
        end
        rd_idx_reg   <= addr_reg;
        sq_idx_reg   <= rd_idx_reg;
        eta_sq_reg   <= deta_sq[ESQ_W-1:0];
        phi_sq_reg   <= dphi_sq[PSQ_W-1:0];
        sum_idx_reg  <= sq_idx_reg;
        sum_reg      <= DR_W'(eta_sq_reg) + DR_W'(phi_sq_reg);
        best_idx_reg <= best_idx_next;
        best_d_reg   <= best_d_next;
        if (cmd.push)
        begin
            matched_reg   <= found_reg;
            jet_index_reg <= idx_ext[JI_W-1:0];
            dist_reg      <= best_d_reg;
            overflow_reg  <= ovf_reg;
        end
    end

    assign status.count_zero = (count_reg == '0);
    assign status.last_addr  = ({1'b0, addr_reg} == (IDX_W + 1)'(count_m1));
    assign status.pipe_busy  = rd_valid_reg || sq_valid_reg || sum_valid_reg;
    assign status.out_free   = !out_valid_reg || !out_stall;

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign jet_index        = jet_index_reg;
    assign distance_squared = dist_reg;
    assign overflow         = overflow_reg;

endmodule

>>> rtl/core/nearest_jet_delta_r_match.sv
`timescale 1ns / 1ps

// Nearest jet delta-R match. Input items carry an action: clear the jet table,
// load one jet (eta, phi), report a constituent of the latest jet (its particle
// id marks the jet as leptonic for electrons, muons and taus), or match a tau.
// Only a match produces a result item: matched, jet_index, distance_squared and
// the overflow flag that tells whether a load was dropped since the last clear.
// Clear, load and constituent items are done in the cycle they are taken, and
// the block stays idle for the next item. A match walks the N stored jets one
// per cycle through the table memory read port, then drains a three-stage
// distance pipeline before its result is ready. The input stall is raised
// after that item is taken until the result moves into the output register,
// and the next item can be taken in the cycle after that move. The result waits in
// the output register, so while the receiver stalls further clear, load and
// constituent items are still taken; a second match finishes its walk and then
// holds until the output register is free. Reset empties the table, clears the
// overflow flag and loads the default match radius with lepton exclusion off.
// Configuration is written through cfg_valid and cfg_ready, which is always
// high, and must only change while the block is idle.
module nearest_jet_delta_r_match
    import njm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              action,
    input  logic signed [ETA_W-1:0] eta,
    input  logic signed [PHI_W-1:0] phi,
    input  logic signed [PID_W-1:0] particle_id,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    matched,
    output logic [JI_W-1:0]         jet_index,
    output logic [DR_W-1:0]         distance_squared,
    output logic                    overflow,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DR_W-1:0]         cfg_data
);

    njm_cmd_t    cmd;
    njm_status_t status;

    // The register file never pushes back.
    assign cfg_ready = 1'b1;

    njm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .status   (status),
        .cmd      (cmd)
    );

    njm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .action           (action),
        .eta              (eta),
        .phi              (phi),
        .particle_id      (particle_id),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .jet_index        (jet_index),
        .distance_squared (distance_squared),
        .overflow         (overflow)
    );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

// Testbench for the nearest jet delta-R matcher.
//
// An initial block builds events (clear, jet loads with their constituents,
// then tau matches) and queues them as items. A clocked driver presents the
// queued items at the falling edge. A clocked monitor samples every handshake
// at the rising edge. It keeps its own copy of the jet table and of the two
// configuration registers, works out the expected match for every accepted
// tau item, and checks each result item against the oldest expected match.
module tb;
    import njm_pkg::*;

    // A match walks the whole table and then drains the distance pipeline.
    localparam int LATENCY        = MAX_JETS + 5;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 75;
    localparam int NUM_PHASES     = 6;
    localparam int IDLE_PERCENT   = 14;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        njm_action_t             act;
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic signed [PID_W-1:0] pid;
    } jet_cmd_t;

    typedef struct {
        logic            matched;
        logic [JI_W-1:0] idx;
        logic [DR_W-1:0] dsq;
        logic            ovf;
    } match_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              action = ACT_CLEAR;
    logic signed [ETA_W-1:0] eta = '0;
    logic signed [PHI_W-1:0] phi = '0;
    logic signed [PID_W-1:0] particle_id = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    matched;
    logic [JI_W-1:0]         jet_index;
    logic [DR_W-1:0]         distance_squared;
    logic                    overflow;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = CFG_MAX_DR;
    logic [DR_W-1:0]         cfg_data = '0;

    nearest_jet_delta_r_match uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .eta              (eta),
        .phi              (phi),
        .particle_id      (particle_id),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .matched          (matched),
        .jet_index        (jet_index),
        .distance_squared (distance_squared),
        .overflow         (overflow),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Items waiting for the driver, and the matches still owed by the block.
    jet_cmd_t      cmds_pending[$];
    match_result_t expected_matches[$];

    // Set by the monitor at each rising edge when the input item was taken,
    // so that the driver knows at the next falling edge to move on.
    logic in_took = 1'b0;

    // While calm is set neither side idles.
    logic calm = 1'b0;

    int fail_count = 0;
    int idle_cycles = 0;
    int queued = 0;

    // Predicted state of the block: the jet table and the two registers.
    logic signed [ETA_W-1:0] table_eta[MAX_JETS];
    logic signed [PHI_W-1:0] table_phi[MAX_JETS];
    logic                    table_lep[MAX_JETS];
    int unsigned             table_count = 0;
    logic                    table_ovf = 1'b0;
    logic [DR_W-1:0]         radius_sq = MAX_DR_RESET;
    logic                    skip_leptons = 1'b0;

    // What the generator believes is stored, used to aim taus at jets and to copy the previous jet.
    logic signed [ETA_W-1:0] gen_eta[MAX_JETS];
    logic signed [PHI_W-1:0] gen_phi[MAX_JETS];
    int                      gen_n = 0;

    // Update the predicted table for one accepted item. A match walks the
    // stored jets in load order and keeps the first jet with the smallest
    // distance that is strictly inside the radius. The phi difference is taken
    // in 16 bits, so it wraps around the full circle just as the block does.
    task automatic apply_item(input jet_cmd_t c);
        logic signed [DETA_W-1:0] de;
        logic signed [PHI_W-1:0]  dp;
        logic signed [PID_W-1:0]  mag;
        longint                   de_l;
        longint                   dp_l;
        logic [DR_W-1:0]          d2;
        match_result_t            r;
        case (c.act)
            ACT_CLEAR:
            begin
                table_count = 0;
                table_ovf   = 1'b0;
            end
            ACT_LOAD:
            begin
                if (table_count < MAX_JETS)
                begin
                    table_eta[table_count] = c.eta;
                    table_phi[table_count] = c.phi;
                    table_lep[table_count] = 1'b0;
                    table_count++;
                end
                else
                begin
                    table_ovf = 1'b1;
                end
            end
            ACT_CONST:
            begin
                // Once a load has been dropped, the latest constituent belongs
                // to a jet that is not in the table, so it marks nothing.
                mag = c.pid[PID_W-1] ? -c.pid : c.pid;
                if (table_count > 0 && !table_ovf &&
                    (mag == PID_ELE || mag == PID_MU || mag == PID_TAU))
                    table_lep[table_count-1] = 1'b1;
            end
            default:
            begin
                r.matched = 1'b0;
                r.idx     = '0;
                r.dsq     = '0;
                for (int j = 0; j < int'(table_count); j++)
                begin
                    if (!(skip_leptons && table_lep[j]))
                    begin
                        de   = {c.eta[ETA_W-1], c.eta} -
                               {table_eta[j][ETA_W-1], table_eta[j]};
                        dp   = c.phi - table_phi[j];
                        de_l = de;
                        dp_l = dp;
                        d2   = DR_W'(de_l * de_l + dp_l * dp_l);
                        if (d2 < radius_sq && (!r.matched || d2 < r.dsq))
                        begin
                            r.matched = 1'b1;
                            r.idx     = JI_W'(j);
                            r.dsq     = d2;
                        end
                    end
                end
                r.ovf = table_ovf;
                expected_matches.insert(expected_matches.size(), r);
            end
        endcase
    endtask

    // Monitor: register writes, accepted input items and result items are all
    // sampled here at the rising edge, before the block updates its outputs.
    always @(posedge clk)
    begin
        jet_cmd_t      c;
        match_result_t e;
        in_took = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MAX_DR:  radius_sq = cfg_data;
                    CFG_EXCLUDE: skip_leptons = cfg_data[0];
                    default:     ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                in_took = 1'b1;
                c.act   = njm_action_t'(action);
                c.eta   = eta;
                c.phi   = phi;
                c.pid   = particle_id;
                apply_item(c);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_matches.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display({"unexpected result: matched=%0d jet_index=%0d",
                                  " dsq=%0d ovf=%0d"},
                                 matched, jet_index, distance_squared, overflow);
                    fail_count++;
                end
                else
                begin
                    e = expected_matches.pop_front();
                    if (matched !== e.matched || jet_index !== e.idx ||
                        distance_squared !== e.dsq || overflow !== e.ovf)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display({"mismatch: expected matched=%0d jet_index=%0d",
                                      " dsq=%0d ovf=%0d, got matched=%0d",
                                      " jet_index=%0d dsq=%0d ovf=%0d"},
                                     e.matched, e.idx, e.dsq, e.ovf,
                                     matched, jet_index, distance_squared, overflow);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Driver: a new item is presented only once the current one has been taken;
    // a stalled item keeps its payload untouched.
    always @(negedge clk)
    begin
        jet_cmd_t cur;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (cmds_pending.size() != 0 &&
                (calm || $urandom_range(99) >= IDLE_PERCENT))
            begin
                cur          = cmds_pending.pop_front();
                in_valid    <= 1'b1;
                action      <= cur.act;
                eta         <= cur.eta;
                phi         <= cur.phi;
                particle_id <= cur.pid;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls at random, except during the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Watchdog: while work is outstanding, some handshake has to complete
    // within the limit, or the run is ended as failed.
    always @(posedge clk)
    begin
        if (rst_n && (cmds_pending.size() != 0 || in_valid || expected_matches.size() != 0) &&
            !(in_valid && !in_stall) && !(out_valid && !out_stall))
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired after %0d cycles without progress", idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
        else
        begin
            idle_cycles = 0;
        end
    end

    task automatic queue_cmd(input njm_action_t act, input logic signed [ETA_W-1:0] e,
                             input logic signed [PHI_W-1:0] p,
                             input logic signed [PID_W-1:0] pid);
        jet_cmd_t c;
        c.act = act;
        c.eta = e;
        c.phi = p;
        c.pid = pid;
        cmds_pending.insert(cmds_pending.size(), c);
        queued++;
    endtask

    // Mostly moderate eta values, now and then anything in the field.
    function automatic logic signed [ETA_W-1:0] rand_eta();
        logic signed [ETA_W-1:0] v;
        if ($urandom_range(7) == 0)
            v = ETA_W'($urandom);
        else
            v = ETA_W'($urandom_range(40000) - 20000);
        return v;
    endfunction

    // Lepton codes of either sign, small near misses, and arbitrary codes.
    function automatic logic signed [PID_W-1:0] rand_pid();
        logic signed [PID_W-1:0] v;
        case ($urandom_range(9))
            0, 1:    v = PID_ELE;
            2, 3:    v = PID_MU;
            4, 5:    v = PID_TAU;
            6:       v = PID_W'($urandom_range(30));
            default: v = PID_W'($urandom);
        endcase
        if ($urandom_range(1) == 1)
            v = -v;
        return v;
    endfunction

    // One event: usually a clear, then jet loads each followed by a few
    // constituents, then some taus, most of them aimed near a stored jet.
    task automatic gen_event(input int n_jets);
        int                      k;
        logic signed [ETA_W-1:0] te;
        logic signed [PHI_W-1:0] tp;
        if ($urandom_range(9) != 0)
        begin
            queue_cmd(ACT_CLEAR, rand_eta(), PHI_W'($urandom), rand_pid());
            gen_n = 0;
        end
        for (int i = 0; i < n_jets; i++)
        begin
            // A copy of the previous jet now and then sets up equal distances.
            if (gen_n != 0 && $urandom_range(9) == 0)
            begin
                te = gen_eta[gen_n-1];
                tp = gen_phi[gen_n-1];
            end
            else
            begin
                te = rand_eta();
                tp = PHI_W'($urandom);
            end
            queue_cmd(ACT_LOAD, te, tp, rand_pid());
            if (gen_n < MAX_JETS)
            begin
                gen_eta[gen_n] = te;
                gen_phi[gen_n] = tp;
                gen_n++;
            end
            repeat ($urandom_range(2))
                queue_cmd(ACT_CONST, rand_eta(), PHI_W'($urandom), rand_pid());
        end
        repeat ($urandom_range(1, 6))
        begin
            if (gen_n != 0 && $urandom_range(3) != 0)
            begin
                k = $urandom_range(gen_n - 1);
                if ($urandom_range(3) == 0)
                begin
                    te = gen_eta[k];
                    tp = gen_phi[k];
                end
                else
                begin
                    te = gen_eta[k] + ETA_W'($urandom_range(10000) - 5000);
                    tp = gen_phi[k] + PHI_W'($urandom_range(10000) - 5000);
                end
            end
            else
            begin
                te = rand_eta();
                tp = PHI_W'($urandom);
            end
            queue_cmd(ACT_MATCH, te, tp, rand_pid());
        end
        // Occasional item of any kind with arbitrary content.
        if ($urandom_range(4) == 0)
            queue_cmd(njm_action_t'($urandom_range(3)), rand_eta(), PHI_W'($urandom),
                      rand_pid());
    endtask

    // Wait until every queued item is taken and every match has come back,
    // then give the block time to finish any item that has no result.
    task automatic settle();
        do
            @(posedge clk);
        while (cmds_pending.size() != 0 || in_valid || expected_matches.size() != 0);
        repeat (LATENCY) @(negedge clk);
    endtask

    task automatic write_reg(input njm_cfg_idx_t idx, input logic [DR_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int phase_start;
        int n_jets;
        bit paused;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset settings. A constituent on an empty
        // table is ignored; the first jet sits at the top corner of eta and
        // phi and gets a lepton mark; the second sits at the bottom corner,
        // and the most positive and most negative codes leave it unmarked. Two
        // identical jets follow to check that the earlier one wins a tie.
        queue_cmd(ACT_CLEAR, '0, '0, '0);
        queue_cmd(ACT_CONST, '0, '0, PID_ELE);
        queue_cmd(ACT_LOAD, 18'sd131071, 16'sd32767, '0);
        queue_cmd(ACT_CONST, '0, '0, -PID_MU);
        queue_cmd(ACT_LOAD, -18'sd131072, -16'sd32768, '0);
        queue_cmd(ACT_CONST, '0, '0, 24'sd8388607);
        queue_cmd(ACT_CONST, '0, '0, -24'sd8388608);
        queue_cmd(ACT_LOAD, 18'sd100, 16'sd200, '0);
        queue_cmd(ACT_LOAD, 18'sd100, 16'sd200, '0);
        queue_cmd(ACT_CONST, '0, '0, PID_TAU);
        // Phi wraps from the top to the bottom of its range: distance one.
        queue_cmd(ACT_MATCH, -18'sd131072, 16'sd32767, '0);
        queue_cmd(ACT_MATCH, 18'sd100, 16'sd200, '0);
        queue_cmd(ACT_MATCH, 18'sd131071, 16'sd32767, '0);
        queue_cmd(ACT_MATCH, 18'sd0, 16'sd0, '0);
        queue_cmd(ACT_MATCH, 18'sd50000, 16'sd0, '0);
        queue_cmd(ACT_CLEAR, '0, '0, '0);
        queue_cmd(ACT_MATCH, 18'sd0, 16'sd0, '0);
        queue_cmd(ACT_CONST, '0, '0, -PID_ELE);
        queue_cmd(ACT_MATCH, -18'sd131072, -16'sd32768, -24'sd1);
        settle();

        // Random part in phases, each under its own register settings.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    write_reg(CFG_MAX_DR, '0);
                    write_reg(CFG_EXCLUDE, 37'd1);
                end
                2:
                begin
                    write_reg(CFG_MAX_DR, '1);
                    write_reg(CFG_EXCLUDE, '0);
                end
                3:
                begin
                    write_reg(CFG_MAX_DR, DR_W'($urandom_range(60000000, 1)));
                    write_reg(CFG_EXCLUDE, 37'd1);
                end
                4:
                begin
                    write_reg(CFG_MAX_DR, 37'd1);
                    write_reg(CFG_EXCLUDE, '0);
                end
                5:
                begin
                    write_reg(CFG_MAX_DR, MAX_DR_RESET);
                    write_reg(CFG_EXCLUDE, 37'd1);
                end
                default: ;
            endcase
            calm = (phase == 3);
            phase_start = queued;
            // A table filled past capacity right away, so that dropped loads
            // and the overflow flag are seen early on.
            if (phase == 0)
                gen_event(MAX_JETS + 4);
            while (queued - phase_start < PHASE_ITEMS)
            begin
                case ($urandom_range(19))
                    0:       n_jets = 0;
                    1:       n_jets = MAX_JETS + $urandom_range(4);
                    default: n_jets = $urandom_range(1, 10);
                endcase
                gen_event(n_jets);
                // Halfway through phase 2 the sender holds off until the
                // block has delivered every outstanding match.
                if (phase == 2 && !paused && queued - phase_start >= PHASE_ITEMS / 2)
                begin
                    settle();
                    paused = 1'b1;
                end
            end
            settle();
        end

        if (fail_count == 0 && expected_matches.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> files.f
rtl/core/njm_pkg.sv
rtl/core/njm_ram.sv
rtl/core/njm_ctrl.sv
rtl/core/njm_dp.sv
rtl/core/nearest_jet_delta_r_match.sv
bench/tb.sv
